@@ design/mwm_pkg.sv @@
// Shared types and constants for the masked weighted mean block.
// Used by the front accumulator, the group queue, the divider back end and the top level.
`default_nettype none

package mwm_pkg;

	// Field widths.
	localparam int VALUE_W  = 24;
	localparam int WEIGHT_W = 16;
	localparam int LIMIT_W  = 9;
	localparam int PROD_W   = VALUE_W + WEIGHT_W + 1;
	localparam int WSUM_W   = 48;
	localparam int WTOT_W   = 24;
	localparam int QUO_W    = 25;
	localparam int STEP_W   = 5;
	localparam int DIVD_W   = WSUM_W + 1;

	// Group limit clamp and the weight used when weighting is off.
	localparam logic [LIMIT_W-1:0]  MAX_MEMBERS = 9'd256;
	localparam logic [LIMIT_W-1:0]  CNT_MAX     = 9'h1FF;
	localparam logic [WEIGHT_W-1:0] ONE_Q8_8    = 16'd256;

	// Saturation bounds.
	localparam logic [WSUM_W-1:0]  WSUM_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [WSUM_W-1:0]  WSUM_MIN = 48'h8000_0000_0000;
	localparam logic [WTOT_W-1:0]  WTOT_MAX = 24'hFF_FFFF;
	localparam logic [VALUE_W-1:0] MEAN_MAX = 24'h7F_FFFF;
	localparam logic [VALUE_W-1:0] MEAN_MIN = 24'h80_0000;
	localparam logic [QUO_W-1:0]   QPOS_MAX = 25'd8388607;
	localparam logic [QUO_W-1:0]   QNEG_MAX = 25'd8388608;

	// Closed group sums handed from the front to the back.
	typedef struct packed {
		logic [WSUM_W-1:0] wsum;
		logic [WTOT_W-1:0] wtot;
		logic              nonempty;
	} group_sum_t;

	// Queue status seen by the producer and consumer.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Divider sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

`default_nettype wire

@@ design/mwm_front.sv @@
// Front end: accepts members, applies the missing flag and group limit, and accumulates sums.
// Depends on mwm_pkg; pushes closed group sums into the group queue.
`default_nettype none

module mwm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          use_weights,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [mwm_pkg::VALUE_W-1:0]  member_value,
	input  wire logic                          member_missing,
	input  wire logic [mwm_pkg::WEIGHT_W-1:0]  member_weight,
	input  wire logic [mwm_pkg::LIMIT_W-1:0]   member_limit,
	input  wire logic                          group_last,
	input  wire mwm_pkg::queue_status_t        q_status,
	output logic                               push,
	output mwm_pkg::group_sum_t                push_data
);

	logic                                   accept;
	logic                                   take;
	logic [mwm_pkg::WEIGHT_W-1:0]           w;
	logic [mwm_pkg::LIMIT_W-1:0]            lim_eff;
	logic [mwm_pkg::LIMIT_W-1:0]            cnt_next;
	logic                                   reached;
	logic                                   advance;

	logic [mwm_pkg::LIMIT_W-1:0]            cnt_q;
	logic                                   lim_reached_q;

	logic                                   valid_s1;
	logic                                   take_s1;
	logic                                   last_s1;
	logic                                   nz_s1;
	logic signed [mwm_pkg::PROD_W-1:0]      prod_s1;
	logic [mwm_pkg::WEIGHT_W-1:0]           w_s1;

	logic [mwm_pkg::WSUM_W-1:0]             wsum_q;
	logic [mwm_pkg::WTOT_W-1:0]             wtot_q;
	logic [mwm_pkg::WSUM_W:0]               wsum_add;
	logic [mwm_pkg::WTOT_W:0]               wtot_add;
	logic [mwm_pkg::WSUM_W-1:0]             wsum_new;
	logic [mwm_pkg::WTOT_W-1:0]             wtot_new;

	// A closed group waits in stage one while the queue is full.
	assign in_stall = valid_s1 && last_s1 && q_status.full;
	assign accept   = in_valid && !in_stall;
	assign advance  = valid_s1 && !(last_s1 && q_status.full);

	// Member classification and the group limit bookkeeping.
	always_comb begin
		take     = !lim_reached_q && !member_missing;
		w        = use_weights ? member_weight : mwm_pkg::ONE_Q8_8;
		lim_eff  = (member_limit > mwm_pkg::MAX_MEMBERS) ? mwm_pkg::MAX_MEMBERS : member_limit;
		cnt_next = (take && cnt_q != mwm_pkg::CNT_MAX) ? cnt_q + 9'd1 : cnt_q;
		reached  = take && (cnt_next >= lim_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			lim_reached_q <= 1'b0;
		end else if (accept) begin
			if (group_last) begin
				cnt_q         <= '0;
				lim_reached_q <= 1'b0;
			end else begin
				cnt_q         <= cnt_next;
				lim_reached_q <= lim_reached_q | reached;
			end
		end
	end

	// Stage one: product register and member flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			take_s1 <= take;
			last_s1 <= group_last;
			nz_s1   <= (cnt_next != '0);
			w_s1    <= w;
			prod_s1 <= member_value * $signed({1'b0, w});
		end
	end

	// Saturating adds into the group sums.
	always_comb begin
		wsum_add = {wsum_q[mwm_pkg::WSUM_W-1], wsum_q}
			+ {{(mwm_pkg::WSUM_W + 1 - mwm_pkg::PROD_W){prod_s1[mwm_pkg::PROD_W-1]}}, prod_s1};
		wtot_add = {1'b0, wtot_q} + {{(mwm_pkg::WTOT_W + 1 - mwm_pkg::WEIGHT_W){1'b0}}, w_s1};
		wsum_new = wsum_q;
		wtot_new = wtot_q;
		if (take_s1) begin
			if (wsum_add[mwm_pkg::WSUM_W] != wsum_add[mwm_pkg::WSUM_W-1]) begin
				wsum_new = wsum_add[mwm_pkg::WSUM_W] ? mwm_pkg::WSUM_MIN : mwm_pkg::WSUM_MAX;
			end else begin
				wsum_new = wsum_add[mwm_pkg::WSUM_W-1:0];
			end
			wtot_new = wtot_add[mwm_pkg::WTOT_W] ? mwm_pkg::WTOT_MAX
				: wtot_add[mwm_pkg::WTOT_W-1:0];
		end
	end

	// Stage two: accumulators, cleared once a group is handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			wtot_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				wsum_q <= '0;
				wtot_q <= '0;
			end else begin
				wsum_q <= wsum_new;
				wtot_q <= wtot_new;
			end
		end
	end

	// Queue write on the closing member.
	always_comb begin
		push               = advance && last_s1;
		push_data.wsum     = wsum_new;
		push_data.wtot     = wtot_new;
		push_data.nonempty = nz_s1 && (wtot_new != '0);
	end

endmodule

`default_nettype wire

@@ design/mwm_queue.sv @@
// Two-entry queue of closed group sums between the front end and the divider.
// Depends on mwm_pkg for the entry type and the status struct.
`default_nettype none

module mwm_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire mwm_pkg::group_sum_t   push_data,
	input  wire logic                  pop,
	output mwm_pkg::group_sum_t        head,
	output mwm_pkg::queue_status_t     status
);

	mwm_pkg::group_sum_t mem_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          fill_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (fill_q == 2'd2);
	assign status.empty = (fill_q == 2'd0);

endmodule

`default_nettype wire

@@ design/mwm_back.sv @@
// Back end: restoring divider that turns group sums into a rounded, saturated mean.
// Depends on mwm_pkg; reads the group queue and drives the result register.
`default_nettype none

module mwm_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mwm_pkg::group_sum_t           head,
	input  wire mwm_pkg::queue_status_t        q_status,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [mwm_pkg::VALUE_W-1:0] mean_value,
	output logic                               mean_valid
);

	mwm_pkg::back_state_t            state_q;
	mwm_pkg::back_state_t            state_next;

	logic [mwm_pkg::DIVD_W-1:0]      rem_q;
	logic [mwm_pkg::WSUM_W-1:0]      dsh_q;
	logic [mwm_pkg::WTOT_W-1:0]      div_q;
	logic [mwm_pkg::QUO_W-1:0]       quo_q;
	logic [mwm_pkg::STEP_W-1:0]      step_q;
	logic                            neg_q;
	logic                            ok_q;
	logic                            ovf_q;

	logic                            out_valid_q;
	logic [mwm_pkg::VALUE_W-1:0]     mean_value_q;
	logic                            mean_valid_q;

	logic [mwm_pkg::WSUM_W-1:0]      mag;
	logic [mwm_pkg::DIVD_W-1:0]      dividend;
	logic                            ovf;
	logic                            ge;
	logic                            load_out;
	logic [mwm_pkg::QUO_W-1:0]       quo_neg;
	logic [mwm_pkg::VALUE_W-1:0]     mean_calc;

	// Dividend: magnitude of the weighted sum plus half the weight sum.
	always_comb begin
		mag      = head.wsum[mwm_pkg::WSUM_W-1] ? (~head.wsum + 48'd1) : head.wsum;
		dividend = {1'b0, mag}
			+ {{(mwm_pkg::DIVD_W - mwm_pkg::WTOT_W + 1){1'b0}}, head.wtot[mwm_pkg::WTOT_W-1:1]};
		ovf      = (rem_q[mwm_pkg::DIVD_W-1:mwm_pkg::QUO_W] >= div_q);
		ge       = (rem_q >= {1'b0, dsh_q});
		load_out = !out_valid_q || !out_stall;
	end

	// Final rounding result with saturation.
	always_comb begin
		quo_neg = ~quo_q + 25'd1;
		if (!ok_q) begin
			mean_calc = '0;
		end else if (neg_q) begin
			mean_calc = (ovf_q || quo_q > mwm_pkg::QNEG_MAX) ? mwm_pkg::MEAN_MIN
				: quo_neg[mwm_pkg::VALUE_W-1:0];
		end else begin
			mean_calc = (ovf_q || quo_q > mwm_pkg::QPOS_MAX) ? mwm_pkg::MEAN_MAX
				: quo_q[mwm_pkg::VALUE_W-1:0];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwm_pkg::BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Sequencer next state and queue pop.
	always_comb begin
		state_next = state_q;
		pop        = 1'b0;
		unique case (state_q)
			mwm_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					pop        = 1'b1;
					state_next = mwm_pkg::BK_PREP;
				end
			end
			mwm_pkg::BK_PREP: begin
				state_next = (!ok_q || ovf) ? mwm_pkg::BK_OUT : mwm_pkg::BK_DIV;
			end
			mwm_pkg::BK_DIV: begin
				if (step_q == '0) begin
					state_next = mwm_pkg::BK_OUT;
				end
			end
			mwm_pkg::BK_OUT: begin
				if (load_out) begin
					state_next = mwm_pkg::BK_IDLE;
				end
			end
			default: state_next = mwm_pkg::BK_IDLE;
		endcase
	end

	// Divider datapath: one quotient bit per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			mwm_pkg::BK_IDLE: begin
				rem_q <= dividend;
				div_q <= head.wtot;
				neg_q <= head.wsum[mwm_pkg::WSUM_W-1];
				ok_q  <= head.nonempty;
			end
			mwm_pkg::BK_PREP: begin
				ovf_q  <= ovf;
				dsh_q  <= {div_q, {(mwm_pkg::WSUM_W - mwm_pkg::WTOT_W){1'b0}}};
				step_q <= 5'(mwm_pkg::QUO_W - 1);
				quo_q  <= '0;
			end
			mwm_pkg::BK_DIV: begin
				if (ge) begin
					rem_q <= rem_q - {1'b0, dsh_q};
				end
				quo_q  <= {quo_q[mwm_pkg::QUO_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - 5'd1;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mwm_pkg::BK_OUT && load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mwm_pkg::BK_OUT && load_out) begin
			mean_value_q <= mean_calc;
			mean_valid_q <= ok_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_value = mean_value_q;
	assign mean_valid = mean_valid_q;

endmodule

`default_nettype wire

@@ design/masked_weighted_mean_top.sv @@
// Top level of the masked weighted mean block: config register, front end, queue, divider.
// Depends on mwm_pkg, mwm_front, mwm_queue and mwm_back.
//
// Channel  Direction  Handshake              Carries
// in       input      in_valid / in_stall    member_value, member_missing, member_weight,
//                                            member_limit, group_last
// out      output     out_valid / out_stall  mean_value, mean_valid
// cfg      input      cfg_valid / cfg_ready  use_weights
//
// Members are taken one per cycle while in_stall is low; a product register and an accumulator stage follow.
// Each closed group goes through the divider's 25-step restoring division, which is skipped when the
// quotient is known to saturate or the group is empty; a two-entry queue lets the
// next groups accumulate meanwhile. Reset is asynchronous and clears all control state;
// use_weights resets to 1. in_stall rises only when a closing member finds the queue full.
`default_nettype none

module masked_weighted_mean_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [mwm_pkg::VALUE_W-1:0]   member_value,
	input  wire logic                                 member_missing,
	input  wire logic [mwm_pkg::WEIGHT_W-1:0]         member_weight,
	input  wire logic [mwm_pkg::LIMIT_W-1:0]          member_limit,
	input  wire logic                                 group_last,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [mwm_pkg::VALUE_W-1:0]        mean_value,
	output logic                                      mean_valid,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic                                 use_weights
);

	logic                    use_weights_q;
	logic                    push;
	logic                    pop;
	mwm_pkg::group_sum_t     push_data;
	mwm_pkg::group_sum_t     head;
	mwm_pkg::queue_status_t  q_status;

	// Configuration register, always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weights_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			use_weights_q <= use_weights;
		end
	end

	// Member accumulation.
	mwm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.use_weights    (use_weights_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.member_value   (member_value),
		.member_missing (member_missing),
		.member_weight  (member_weight),
		.member_limit   (member_limit),
		.group_last     (group_last),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	// Group sum queue.
	mwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Division and result register.
	mwm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mean_value (mean_value),
		.mean_valid (mean_valid)
	);

	// The front end never writes a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("group pushed into a full queue");

	// The divider never reads an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("group popped from an empty queue");

	// An invalid mean always carries a zero value.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mean_valid) |-> (mean_value == '0))
		else $error("invalid mean with nonzero value");

	// A closing member that is stalled means the queue was full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_status.full)
		else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

@@ test/masked_weighted_mean_top_tb.sv @@
// Self-checking testbench for masked_weighted_mean_top: directed groups, random groups,
// back-pressure and config changes, with a bit-exact group mean predictor.
// Depends on mwm_pkg and the masked_weighted_mean_top RTL.
`default_nettype none

module masked_weighted_mean_top_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_GAP    = 64;
	localparam int HOLD_CYCLES = 400;
	localparam longint WSUM_HI = (longint'(1) <<< 47) - 1;
	localparam longint WSUM_LO = -(longint'(1) <<< 47);
	localparam longint unsigned WTOT_HI = 64'hFF_FFFF;
	localparam int COUNT_HI = 511;

	typedef struct packed {
		logic signed [mwm_pkg::VALUE_W-1:0] value;
		logic                               missing;
		logic [mwm_pkg::WEIGHT_W-1:0]       weight;
		logic [mwm_pkg::LIMIT_W-1:0]        limit;
		logic                               last;
	} member_t;

	typedef struct packed {
		logic signed [mwm_pkg::VALUE_W-1:0] value;
		logic                               valid;
	} mean_t;

	// Ports of the block; the inputs are known from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [mwm_pkg::VALUE_W-1:0] member_value = '0;
	logic member_missing = 1'b0;
	logic [mwm_pkg::WEIGHT_W-1:0] member_weight = '0;
	logic [mwm_pkg::LIMIT_W-1:0] member_limit = '0;
	logic group_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [mwm_pkg::VALUE_W-1:0] mean_value;
	logic mean_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic use_weights = 1'b1;

	// Predictor state: configuration and the running sums of the open group.
	bit weights_on = 1'b1;
	longint grp_wsum = 0;
	longint unsigned grp_wtot = 0;
	int grp_count = 0;
	bit grp_full = 1'b0;
	mean_t mean_q[$];

	// Bookkeeping.
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycle_count = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int run_left = 0;
	bit run_stall = 1'b0;
	mean_t oldest_mean;

	masked_weighted_mean_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.member_value   (member_value),
		.member_missing (member_missing),
		.member_weight  (member_weight),
		.member_limit   (member_limit),
		.group_last     (group_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mean_value     (mean_value),
		.mean_valid     (mean_valid),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.use_weights    (use_weights)
	);

	// Clock with a period of four time units.
	always #2 clk = ~clk;

	// Run limit: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, mean_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("Mismatch in %s of result %0d: got %0d, expected %0d",
			what, results_seen, got, want);
		mismatches++;
	endtask

	// Add one accepted member to the open group and close the group on its last member.
	task automatic predict_member(member_t m);
		int lim;
		longint unsigned w;
		longint sum;
		longint unsigned mag;
		longint unsigned q;
		bit neg;
		mean_t r;
		lim = m.limit;
		if (lim > mwm_pkg::MAX_MEMBERS)
			lim = mwm_pkg::MAX_MEMBERS;
		if (!grp_full && !m.missing) begin
			w = weights_on ? m.weight : mwm_pkg::ONE_Q8_8;
			sum = grp_wsum + longint'($signed(m.value)) * longint'(w);
			if (sum > WSUM_HI)
				sum = WSUM_HI;
			if (sum < WSUM_LO)
				sum = WSUM_LO;
			grp_wsum = sum;
			grp_wtot = (grp_wtot + w > WTOT_HI) ? WTOT_HI : grp_wtot + w;
			if (grp_count < COUNT_HI)
				grp_count++;
			if (grp_count >= lim)
				grp_full = 1'b1;
		end
		if (m.last) begin
			r = '0;
			if (grp_count != 0 && grp_wtot != 0) begin
				neg = grp_wsum < 0;
				mag = neg ? longint'(-grp_wsum) : longint'(grp_wsum);
				// Round to nearest, ties away from zero, then saturate.
				q = (mag + grp_wtot / 2) / grp_wtot;
				if (neg)
					r.value = (q > 64'd8388608) ? mwm_pkg::MEAN_MIN : 24'(-longint'(q));
				else
					r.value = (q > 64'd8388607) ? mwm_pkg::MEAN_MAX : 24'(q);
				r.valid = 1'b1;
			end
			mean_q.push_back(r);
			grp_wsum = 0;
			grp_wtot = 0;
			grp_count = 0;
			grp_full = 1'b0;
		end
	endtask

	// Result checker: every transaction on the output is compared with the oldest mean.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (mean_q.size() == 0) begin
				report_mismatch("unexpected transaction", mean_value, 0);
			end else begin
				oldest_mean = mean_q.pop_front();
				if (mean_value !== oldest_mean.value)
					report_mismatch("mean_value", mean_value, oldest_mean.value);
				if (mean_valid !== oldest_mean.valid)
					report_mismatch("mean_valid", mean_valid, oldest_mean.valid);
			end
			results_seen++;
		end
	end

	// Receiver: random stall runs, quiet stretches and requested long hold-offs.
	always @(posedge clk) begin
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (recv_quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						run_stall = 1'b0;
						run_left = $urandom_range(1, 12);
					end
					9: begin
						run_stall = 1'b1;
						run_left = $urandom_range(15, 50);
					end
					default: begin
						run_stall = 1'b1;
						run_left = $urandom_range(1, 3);
					end
				endcase
			end
			run_left--;
			out_stall <= run_stall;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic member_t mk_member(int value, bit missing, int weight, int limit,
		bit last);
		member_t m;
		m.value = 24'(value);
		m.missing = missing;
		m.weight = 16'(weight);
		m.limit = 9'(limit);
		m.last = last;
		return m;
	endfunction

	function automatic logic [mwm_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 19))
			0: return mwm_pkg::MEAN_MAX;
			1: return mwm_pkg::MEAN_MIN;
			2: return '0;
			3: return '1;
			4: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [mwm_pkg::WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 19))
			0, 1: return '0;
			2: return '1;
			3: return mwm_pkg::ONE_Q8_8;
			4: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one member after a random gap and record it once it is accepted.
	task automatic send_member(member_t m);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		member_value <= m.value;
		member_missing <= m.missing;
		member_weight <= m.weight;
		member_limit <= m.limit;
		group_last <= m.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_member(m);
		items_sent++;
	endtask

	// Stop offering members and wait until every expected mean has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (mean_q.size() != 0)
			@(posedge clk);
	endtask

	// Configuration is changed only with the block idle.
	task automatic set_use_weights(bit on);
		drain_results();
		repeat (IDLE_GAP) @(posedge clk);
		use_weights <= on;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		weights_on = on;
	endtask

	// One group of random members; the limit is mostly shared, sometimes per member.
	task automatic send_group(int size, int limit, int missing_pct);
		member_t m;
		for (int i = 0; i < size; i++) begin
			m.value = rand_value();
			m.missing = $urandom_range(0, 99) < missing_pct;
			m.weight = rand_weight();
			m.limit = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'(limit);
			m.last = (i == size - 1);
			send_member(m);
		end
	endtask

	task automatic test_directed_weighted();
		// Field extremes, one member per group.
		send_member(mk_member(8388607, 0, 65535, 1, 1));
		send_member(mk_member(-8388608, 0, 1, 511, 1));
		// All members missing gives an invalid mean.
		send_member(mk_member(8388607, 1, 65535, 3, 0));
		send_member(mk_member(-8388608, 1, 65535, 3, 1));
		// Zero weight sum gives an invalid mean.
		send_member(mk_member(12345, 0, 0, 5, 1));
		// A zero limit still takes the first valid member.
		send_member(mk_member(65536, 0, 256, 0, 0));
		send_member(mk_member(-65536, 0, 256, 0, 1));
		// Ties round away from zero on both signs.
		send_member(mk_member(1, 0, 256, 4, 0));
		send_member(mk_member(2, 0, 256, 4, 1));
		send_member(mk_member(-1, 0, 256, 4, 0));
		send_member(mk_member(-2, 0, 256, 4, 1));
		// Members after the limit are ignored, but the last one still closes the group.
		send_member(mk_member(777, 1, 50, 2, 0));
		send_member(mk_member(5, 0, 3, 2, 0));
		send_member(mk_member(7, 0, 1, 2, 0));
		send_member(mk_member(999, 0, 9, 2, 1));
		// Zero-weight member mixed with a weighted one.
		send_member(mk_member(1000, 0, 0, 8, 0));
		send_member(mk_member(-3000, 0, 2, 8, 1));
	endtask

	task automatic test_directed_unweighted();
		// With weighting off, a zero weight still counts as one.
		send_member(mk_member(1000, 0, 0, 9, 1));
		send_member(mk_member(-8388608, 0, 65535, 256, 0));
		send_member(mk_member(8388607, 0, 0, 256, 1));
		send_member(mk_member(42, 1, 7, 0, 1));
	endtask

	task automatic test_random(int n_items);
		int stop_at;
		int size;
		int limit;
		int missing_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 19))
				0: size = $urandom_range(7, 24);
				1: size = 1;
				default: size = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 4))
				0, 1: limit = $urandom_range(0, 4);
				2: limit = $urandom_range(256, 511);
				default: limit = $urandom_range(0, 511);
			endcase
			case ($urandom_range(0, 9))
				0: missing_pct = 0;
				1: missing_pct = 90;
				default: missing_pct = 15;
			endcase
			send_group(size, limit, missing_pct);
		end
	endtask

	// A limit above the maximum is clamped: members past the 256th are dropped.
	task automatic test_limit_clamp();
		send_quiet = 1'b1;
		send_group(258, 300, 0);
		send_quiet = 1'b0;
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		send_quiet = 1'b1;
		hold_ask <= hold_ask + 1;
		for (int i = 0; i < 40; i++)
			send_group($urandom_range(1, 2), $urandom_range(0, 511), 10);
		send_quiet = 1'b0;
		drain_results();
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_quiet_stream();
		send_quiet = 1'b1;
		recv_quiet <= 1'b1;
		test_random(60);
		send_quiet = 1'b0;
		recv_quiet <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_weighted();
		set_use_weights(1'b0);
		test_directed_unweighted();
		set_use_weights(1'b1);
		test_random(100);
		set_use_weights(1'b0);
		test_random(60);
		set_use_weights(1'b1);
		test_limit_clamp();
		test_backpressure();
		test_quiet_stream();
		set_use_weights(1'b0);
		test_random(50);
		set_use_weights(1'b1);
		test_random(50);

		drain_results();
		repeat (IDLE_GAP) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
design/mwm_pkg.sv
design/mwm_front.sv
design/mwm_queue.sv
design/mwm_back.sv
design/masked_weighted_mean_top.sv
test/masked_weighted_mean_top_tb.sv
